[rtl/ghcm_pkg.sv]
// ----------------------------------------------------------------------------
// ghcm_pkg
// Shared types and constants for the greedy hit cluster matcher: request and
// result payloads, request codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package ghcm_pkg;

    localparam int MAX_CLUSTERS_DEF = 256;
    localparam int ANGLE_BITS_DEF   = 16;

    localparam int POS_W     = 20;
    localparam int RAD_W     = 19;
    localparam int ANG_W     = 16;
    localparam int CUT_W     = 19;
    localparam int IDX_OUT_W = 8;
    localparam int MCNT_W    = 9;
    localparam int MAG_W     = 21;
    localparam int K_W       = 23;
    localparam int HRK_W     = RAD_W + K_W;
    localparam int HRK_HALF  = HRK_W / 2;
    localparam int ENTRY_W   = POS_W + 1;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 19;

    // round(2*pi * 2^20)
    localparam logic [K_W-1:0] TWO_PI_Q20 = 23'd6588397;

    localparam logic [CUT_W-1:0]  RADIAL_CUT_RST = 19'd700;
    localparam logic [CUT_W-1:0]  ARC_CUT_RST    = 19'd200;
    localparam logic [MCNT_W-1:0] MCNT_MAX       = '1;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_MATCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_CUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARC_CUT    = 2'd2;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [POS_W-1:0] cluster_position;
        logic [RAD_W-1:0]        hit_radius;
        logic signed [ANG_W-1:0] hit_angle;
    } req_t;

    typedef struct packed {
        logic                    found;
        logic [IDX_OUT_W-1:0]    cluster_index;
        logic signed [POS_W-1:0] residual;
        logic [MCNT_W-1:0]       match_count;
        logic                    list_full;
    } rsp_t;

    // candidate entry read from the cluster store
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
    } cand_t;

    // residual of one candidate in sign and magnitude form
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [POS_W-1:0] pos;
    } resid_t;

endpackage

[rtl/ghcm_ram.sv]
// ----------------------------------------------------------------------------
// ghcm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ghcm_ram #(
    parameter int WIDTH = ghcm_pkg::ENTRY_W,
    parameter int DEPTH = ghcm_pkg::MAX_CLUSTERS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ghcm_resid.sv]
// ----------------------------------------------------------------------------
// ghcm_resid
// Two-stage residual unit shared by every cluster of a scan: radial
// difference, or radius times wrapped angle difference with rounding.
// ----------------------------------------------------------------------------
module ghcm_resid #(
    parameter int ANGLE_BITS = ghcm_pkg::ANGLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               mode,
    input  logic [ghcm_pkg::RAD_W-1:0]         hit_radius,
    input  logic signed [ghcm_pkg::ANG_W-1:0]  hit_angle,
    input  logic [ghcm_pkg::HRK_W-1:0]         hrk,
    input  ghcm_pkg::cand_t                    cand,
    output logic                               busy,
    output ghcm_pkg::resid_t                   resid
);

    localparam int HALF   = ghcm_pkg::HRK_HALF;
    localparam int PROD_W = ANGLE_BITS + HALF;
    localparam int SUM_W  = ANGLE_BITS + ghcm_pkg::HRK_W + 1;
    localparam int SHIFT  = ANGLE_BITS + 20;
    localparam logic [SUM_W-1:0] ROUND_C = SUM_W'(1) << (ANGLE_BITS + 19);

    logic [ghcm_pkg::POS_W-1:0] ha_ext;
    logic [ANGLE_BITS-1:0]      ang_d;
    logic                       ang_neg;
    logic [ANGLE_BITS-1:0]      ang_mag;
    logic [ghcm_pkg::MAG_W-1:0] rad_diff;
    logic                       rad_neg;
    logic [ghcm_pkg::MAG_W-1:0] rad_mag;
    logic [PROD_W-1:0]          plo;
    logic [PROD_W-1:0]          phi;

    logic                       b_valid_reg;
    logic                       b_rad_neg_reg;
    logic [ghcm_pkg::MAG_W-1:0] b_rad_mag_reg;
    logic                       b_ang_neg_reg;
    logic [PROD_W-1:0]          b_plo_reg;
    logic [PROD_W-1:0]          b_phi_reg;
    logic [ghcm_pkg::POS_W-1:0] b_pos_reg;

    logic [SUM_W-1:0]           ang_sum;
    logic [ghcm_pkg::MAG_W-1:0] ang_r;
    logic                       resid_valid_reg;
    logic                       resid_neg_reg;
    logic [ghcm_pkg::MAG_W-1:0] resid_mag_reg;
    logic [ghcm_pkg::POS_W-1:0] resid_pos_reg;

    always_comb
    begin
        ha_ext   = {{(ghcm_pkg::POS_W - ghcm_pkg::ANG_W){hit_angle[ghcm_pkg::ANG_W-1]}},
                    hit_angle};
        // binary angle difference wraps naturally in ANGLE_BITS bits
        ang_d    = ha_ext[ANGLE_BITS-1:0] - cand.pos[ANGLE_BITS-1:0];
        ang_neg  = ang_d[ANGLE_BITS-1];
        ang_mag  = ang_neg ? (~ang_d + 1'b1) : ang_d;
        rad_diff = {cand.pos[ghcm_pkg::POS_W-1], cand.pos} - {2'b00, hit_radius};
        rad_neg  = rad_diff[ghcm_pkg::MAG_W-1];
        rad_mag  = rad_neg ? (ghcm_pkg::MAG_W'(0) - rad_diff) : rad_diff;
        // radius*2pi is split in halves to keep each product narrow
        plo      = PROD_W'(ang_mag) * PROD_W'(hrk[HALF-1:0]);
        phi      = PROD_W'(ang_mag) * PROD_W'(hrk[ghcm_pkg::HRK_W-1:HALF]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= cand.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        b_rad_neg_reg <= rad_neg;
        b_rad_mag_reg <= rad_mag;
        b_ang_neg_reg <= ang_neg;
        b_plo_reg     <= plo;
        b_phi_reg     <= phi;
        b_pos_reg     <= cand.pos;
    end

    always_comb
    begin
        ang_sum = SUM_W'({b_phi_reg, {HALF{1'b0}}}) + SUM_W'(b_plo_reg) + ROUND_C;
        ang_r   = ang_sum[SHIFT + ghcm_pkg::MAG_W - 1:SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resid_valid_reg <= 1'b0;
        end
        else
        begin
            resid_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        resid_neg_reg <= mode ? b_ang_neg_reg : b_rad_neg_reg;
        resid_mag_reg <= mode ? ang_r : b_rad_mag_reg;
        resid_pos_reg <= b_pos_reg;
    end

    always_comb
    begin
        resid.valid = resid_valid_reg;
        resid.neg   = resid_neg_reg;
        resid.mag   = resid_mag_reg;
        resid.pos   = resid_pos_reg;
    end

    assign busy = b_valid_reg;

endmodule

[rtl/greedy_hit_cluster_matcher_core.sv]
// ----------------------------------------------------------------------------
// greedy_hit_cluster_matcher_core
// Cluster list with matched marks; greedy nearest-cluster match of hits
// within a configurable cut, radial or radius times angle residual.
// ----------------------------------------------------------------------------
// Clear, load and unused requests are handled in the idle state and their
// result is registered at once when the output register is free. A match
// request holds off the next request transfer while it scans the N stored
// clusters: the cluster store RAM has one read port, so the scan reads one
// entry per cycle and feeds it through the two-stage residual unit, then the
// best candidate is marked in the store. The drain ends sooner when the last
// stored clusters are already matched, and a match on an empty list goes
// straight to the finish state. A result blocked by a stalled output waits in
// the hold state until the output register is free. Matched marks live beside
// the positions in the same RAM and are written fresh by every load, so a
// clear only resets the counts and no clearing pass is ever needed. A finished
// result waits in the output register while the next request is taken.
module greedy_hit_cluster_matcher_core #(
    parameter int MAX_CLUSTERS = ghcm_pkg::MAX_CLUSTERS_DEF,
    parameter int ANGLE_BITS   = ghcm_pkg::ANGLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  ghcm_pkg::req_t                    req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output ghcm_pkg::rsp_t                    rsp_data,
    input  logic                              cfg_we,
    input  logic [ghcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ghcm_pkg::CFG_W-1:0]        cfg_data
);

    localparam int AW    = $clog2(MAX_CLUSTERS);
    localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_HOLD
    } state_t;

    state_t                           state_reg;
    logic                             mode_reg;
    logic [ghcm_pkg::CUT_W-1:0]       radial_cut_reg;
    logic [ghcm_pkg::CUT_W-1:0]       arc_cut_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic [ghcm_pkg::MCNT_W-1:0]      matches_reg;
    logic [AW-1:0]                    scan_idx_reg;
    logic [ghcm_pkg::RAD_W-1:0]       hr_reg;
    logic signed [ghcm_pkg::ANG_W-1:0] ha_reg;
    logic [ghcm_pkg::HRK_W-1:0]       hrk_reg;
    logic [ghcm_pkg::CUT_W-1:0]       cut_reg;
    logic                             have_reg;
    logic [ghcm_pkg::MAG_W-1:0]       best_mag_reg;
    logic                             best_neg_reg;
    logic [AW-1:0]                    best_idx_reg;
    logic [ghcm_pkg::POS_W-1:0]       best_pos_reg;
    logic                             rsp_valid_reg;
    ghcm_pkg::rsp_t                   rsp_reg;
    ghcm_pkg::rsp_t                   pend_reg;

    logic                             issue_valid_reg;
    logic [AW-1:0]                    idx_pipe_reg [3];

    logic                             req_fire;
    logic                             rsp_free;
    logic                             list_full_now;
    logic                             scan_last;
    logic                             drained;
    logic                             emit;
    ghcm_pkg::rsp_t                   rsp_next;
    logic [ghcm_pkg::MCNT_W-1:0]      matches_next;
    logic [ghcm_pkg::MAG_W-1:0]       best_signed;

    logic                             ram_we;
    logic [AW-1:0]                    ram_waddr;
    logic [ghcm_pkg::ENTRY_W-1:0]     ram_wdata;
    logic [ghcm_pkg::ENTRY_W-1:0]     ram_rdata;

    ghcm_pkg::cand_t                  cand;
    ghcm_pkg::resid_t                 resid;
    logic                             unit_busy;

    assign req_fire      = req_valid && !req_stall;
    assign rsp_free      = !rsp_valid_reg || !rsp_stall;
    assign list_full_now = (count_reg == CNT_W'(MAX_CLUSTERS));
    assign scan_last     = (CNT_W'(scan_idx_reg) == (count_reg - CNT_W'(1)));
    assign drained       = !issue_valid_reg && !unit_busy && !resid.valid;
    assign matches_next  = (matches_reg == ghcm_pkg::MCNT_MAX) ? matches_reg
                                                               : matches_reg + 1'b1;
    assign best_signed   = best_neg_reg ? (ghcm_pkg::MAG_W'(0) - best_mag_reg)
                                        : best_mag_reg;

    always_comb
    begin
        emit     = 1'b0;
        rsp_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req_data.req_type != ghcm_pkg::REQ_MATCH))
                begin
                    emit = 1'b1;
                    if (req_data.req_type != ghcm_pkg::REQ_CLEAR)
                    begin
                        rsp_next.match_count = matches_reg;
                    end
                    if (req_data.req_type == ghcm_pkg::REQ_LOAD)
                    begin
                        rsp_next.list_full = list_full_now;
                    end
                end
            end
            ST_FINISH:
            begin
                emit = 1'b1;
                if (have_reg)
                begin
                    rsp_next.found         = 1'b1;
                    rsp_next.cluster_index = ghcm_pkg::IDX_OUT_W'(best_idx_reg);
                    rsp_next.residual      = $signed(best_signed[ghcm_pkg::POS_W-1:0]);
                    rsp_next.match_count   = matches_next;
                end
                else
                begin
                    rsp_next.match_count = matches_reg;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // load writes an unmarked entry, a finished match re-writes its winner marked
    always_comb
    begin
        if (state_reg == ST_FINISH)
        begin
            ram_we    = have_reg;
            ram_waddr = best_idx_reg;
            ram_wdata = {1'b1, best_pos_reg};
        end
        else
        begin
            ram_we    = (state_reg == ST_IDLE) && req_fire
                        && (req_data.req_type == ghcm_pkg::REQ_LOAD) && !list_full_now;
            ram_waddr = count_reg[AW-1:0];
            ram_wdata = {1'b0, req_data.cluster_position};
        end
    end

    ghcm_ram #(
        .WIDTH (ghcm_pkg::ENTRY_W),
        .DEPTH (MAX_CLUSTERS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == ST_SCAN),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // already matched entries drop out of the scan here
    assign cand.valid = issue_valid_reg && !ram_rdata[ghcm_pkg::ENTRY_W-1];
    assign cand.pos   = ram_rdata[ghcm_pkg::POS_W-1:0];

    ghcm_resid #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_resid (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .hit_radius (hr_reg),
        .hit_angle  (ha_reg),
        .hrk        (hrk_reg),
        .cand       (cand),
        .busy       (unit_busy),
        .resid      (resid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_valid_reg <= 1'b0;
        end
        else
        begin
            issue_valid_reg <= (state_reg == ST_SCAN);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_pipe_reg[0] <= scan_idx_reg;
        idx_pipe_reg[1] <= idx_pipe_reg[0];
        idx_pipe_reg[2] <= idx_pipe_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            radial_cut_reg <= ghcm_pkg::RADIAL_CUT_RST;
            arc_cut_reg    <= ghcm_pkg::ARC_CUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ghcm_pkg::REG_MATCH_MODE: mode_reg       <= cfg_data[0];
                ghcm_pkg::REG_RADIAL_CUT: radial_cut_reg <= cfg_data;
                ghcm_pkg::REG_ARC_CUT:    arc_cut_reg    <= cfg_data;
                default:                  mode_reg       <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            matches_reg   <= '0;
            have_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_reg && rsp_stall;

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        case (req_data.req_type)
                            ghcm_pkg::REQ_CLEAR:
                            begin
                                count_reg   <= '0;
                                matches_reg <= '0;
                            end
                            ghcm_pkg::REQ_LOAD:
                            begin
                                if (!list_full_now)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            ghcm_pkg::REQ_MATCH:
                            begin
                                hr_reg       <= req_data.hit_radius;
                                ha_reg       <= req_data.hit_angle;
                                hrk_reg      <= ghcm_pkg::HRK_W'(req_data.hit_radius)
                                                * ghcm_pkg::HRK_W'(ghcm_pkg::TWO_PI_Q20);
                                cut_reg      <= mode_reg ? arc_cut_reg : radial_cut_reg;
                                best_mag_reg <= ghcm_pkg::MAG_W'(mode_reg ? arc_cut_reg
                                                                          : radial_cut_reg);
                                have_reg     <= 1'b0;
                                scan_idx_reg <= '0;
                                state_reg    <= (count_reg == '0) ? ST_FINISH : ST_SCAN;
                            end
                            default:
                            begin
                                count_reg <= count_reg;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (scan_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (drained)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (have_reg)
                    begin
                        matches_reg <= matches_next;
                    end
                end
                ST_HOLD:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg       <= pend_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // later candidate wins on equal magnitude
            if (resid.valid && (resid.mag <= best_mag_reg))
            begin
                best_mag_reg <= resid.mag;
                best_neg_reg <= resid.neg;
                best_idx_reg <= idx_pipe_reg[2];
                best_pos_reg <= resid.pos;
                have_reg     <= 1'b1;
            end

            if (emit)
            begin
                if (rsp_free)
                begin
                    rsp_reg       <= rsp_next;
                    rsp_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                else
                begin
                    pend_reg  <= rsp_next;
                    state_reg <= ST_HOLD;
                end
            end
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CLUSTERS))
        else $error("cluster count above list size");

    a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (CNT_W'(scan_idx_reg) < count_reg))
        else $error("scan address beyond stored clusters");

    a_winner_in_cut: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && have_reg) |-> (best_mag_reg <= ghcm_pkg::MAG_W'(cut_reg)))
        else $error("chosen residual outside cut");

    a_resid_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        resid.valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("residual arrived outside a scan");

    a_found_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.found) |-> (rsp_data.match_count != '0))
        else $error("match reported with zero match count");
`endif

endmodule
